### rtl/core/consistent_hash_ring_assert.svh
// ----------------------------------------------------------------------------
// consistent_hash_ring_assert.svh
// Assertion macros shared by the ring checker.
// ----------------------------------------------------------------------------
`ifndef CONSISTENT_HASH_RING_ASSERT_SVH
`define CONSISTENT_HASH_RING_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/chr_pkg.sv
// ----------------------------------------------------------------------------
// chr_pkg
// Types and constants of the consistent hash ring.
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam int KEY_W        = 17;
  localparam int HND_W        = 4;
  localparam int MAX_SERVERS  = 16;
  localparam int CNT_W        = 5;
  localparam int MAX_REPLICAS = 8;
  localparam int REP_W        = 4;
  localparam int CFG_RS_W     = 11;
  localparam int SQ_W         = 2 * KEY_W;
  localparam int HX_W         = 2 * KEY_W + 1;

  // action codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_PRESENT = 3'd4;

  // sequencer states
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SQR   = 8'b0000_0100,
    S_HASH  = 8'b0000_1000,
    S_WAIT  = 8'b0001_0000,
    S_RD    = 8'b0010_0000,
    S_CHK   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // status of the modulo unit
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

### rtl/core/chr_ram.sv
// ----------------------------------------------------------------------------
// chr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/chr_mod.sv
// ----------------------------------------------------------------------------
// chr_mod
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module chr_mod #(
  parameter int XW = 35,
  parameter int DW = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [XW-1:0]             x,
  input  logic [DW-1:0]             d,
  output chr_pkg::mod_stat_t        stat,
  output logic [DW-1:0]             rem
);
  import chr_pkg::*;

  localparam int CW = $clog2(XW + 1);

  logic [XW-1:0] x_r, x_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  // shift in next bit, subtract when it fits
  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, x_r[XW-1]};
    if (start) begin
      x_nxt    = x;
      rem_nxt  = '0;
      cnt_nxt  = CW'(XW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[XW-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        rem_nxt = DW'(trial - {1'b0, d});
      end else begin
        rem_nxt = trial[DW-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

### rtl/core/consistent_hash_ring.sv
// ----------------------------------------------------------------------------
// consistent_hash_ring
// Consistent-hash ring with virtual nodes: add, remove and look up servers.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | slave     | tuser: action; tdata: server_handle, key
// out_    | master    | tdata: status, owner
// cfg_    | APB       | 0x0 ring_size, 0x4 replicas
//
// After reset a clearing pass writes every ring slot, with in_tready low.
// A working request squares its key, then per replica runs the shared modulo
// unit and probes the ring RAM slot by slot (S_RD, then S_CHK), one RAM
// read port. A lookup is one hash plus probes. Unknown, full and duplicate
// requests, empty lookups and unused actions skip to S_DONE. in_tready is
// low while a request is worked on; a held result stalls only the next finish.
// ----------------------------------------------------------------------------
module consistent_hash_ring #(
  parameter int RING_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] server_handle, [20:4] key, [23:21] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] status, [6:3] owner, [7] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import chr_pkg::*;

  localparam int IW = $clog2(RING_DEPTH);
  localparam int SW = IW + 1;

  state_t                state_r, state_nxt;
  logic [CFG_RS_W-1:0]   ring_size_r;
  logic [REP_W-1:0]      replicas_r;
  logic [SW-1:0]         s_eff, s_r, s_nxt;
  logic [REP_W-1:0]      r_eff, r_r, r_nxt;
  logic [1:0]            act_r, act_nxt;
  logic [HND_W-1:0]      hnd_r, hnd_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [SQ_W-1:0]       ksq_r, ksq_nxt;
  logic [REP_W-1:0]      j_r, j_nxt;
  logic [IW-1:0]         h_r, h_nxt;
  logic [SW-1:0]         n_r, n_nxt;
  logic [2:0]            status_r, status_nxt;
  logic [HND_W-1:0]      owner_r, owner_nxt;
  logic [IW-1:0]         clr_r, clr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [MAX_SERVERS-1:0] present_r, present_nxt;
  logic [KEY_W-1:0]      keys_r [MAX_SERVERS];
  logic                  key_we;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_data_r, out_data_nxt;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [HND_W:0]        ram_wdata;
  logic [HND_W:0]        ram_rdata;
  logic                  rd_taken;
  logic [HND_W-1:0]      rd_owner;

  logic                  mod_start;
  logic [HX_W-1:0]       mod_x;
  mod_stat_t             mod_stat;
  logic [SW-1:0]         mod_rem;

  logic [1:0]            in_act;
  logic [HND_W-1:0]      in_hnd;
  logic [KEY_W-1:0]      in_key;
  logic [9:0]            need;
  logic [7:0]            jsq;
  logic [SW-1:0]         h_inc;
  logic [SW-1:0]         rem_inc;
  logic [SW-1:0]         n_inc;
  logic                  last_rep;
  logic                  cfg_wr;

  // configuration registers
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= CFG_RS_W'(1024);
      replicas_r  <= REP_W'(3);
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        replicas_r <= cfg_pwdata[REP_W-1:0];
      end else begin
        ring_size_r <= cfg_pwdata[CFG_RS_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2]) begin
      cfg_prdata = {{(32-REP_W){1'b0}}, replicas_r};
    end else begin
      cfg_prdata = {{(32-CFG_RS_W){1'b0}}, ring_size_r};
    end
  end

  // clamp registers to their working range
  always_comb begin
    if (ring_size_r < CFG_RS_W'(2)) begin
      s_eff = SW'(2);
    end else if (32'(ring_size_r) > RING_DEPTH) begin
      s_eff = SW'(RING_DEPTH);
    end else begin
      s_eff = SW'(ring_size_r);
    end
    if (replicas_r == '0) begin
      r_eff = REP_W'(1);
    end else if (replicas_r > REP_W'(MAX_REPLICAS)) begin
      r_eff = REP_W'(MAX_REPLICAS);
    end else begin
      r_eff = replicas_r;
    end
  end

  // request fields
  assign in_act = in_tuser;
  assign in_hnd = in_tdata[HND_W-1:0];
  assign in_key = in_tdata[HND_W +: KEY_W];
  assign need   = (10'(count_r) + 10'd1) * 10'(r_eff);

  // hash argument for the shared modulo unit
  assign jsq = j_r * j_r;
  always_comb begin
    if (act_r == ACT_LOOKUP) begin
      mod_x = HX_W'(ksq_r) + HX_W'({key_r, 1'b0}) + HX_W'(17);
    end else begin
      mod_x = HX_W'(ksq_r) + HX_W'(jsq) + HX_W'({j_r, 1'b0}) + HX_W'(25);
    end
  end

  chr_mod #(
    .XW (HX_W),
    .DW (SW)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .x     (mod_x),
    .d     (s_r),
    .stat  (mod_stat),
    .rem   (mod_rem)
  );

  // ring slots: {taken, owner}
  chr_ram #(
    .WIDTH (HND_W + 1),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (h_r),
    .rdata (ram_rdata)
  );

  assign rd_taken  = ram_rdata[HND_W];
  assign rd_owner  = ram_rdata[HND_W-1:0];
  assign h_inc     = SW'(h_r) + SW'(1);
  assign rem_inc   = mod_rem + SW'(1);
  assign n_inc     = n_r + SW'(1);
  assign last_rep  = ((j_r + REP_W'(1)) == r_r);
  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    r_nxt         = r_r;
    act_nxt       = act_r;
    hnd_nxt       = hnd_r;
    key_nxt       = key_r;
    ksq_nxt       = ksq_r;
    j_nxt         = j_r;
    h_nxt         = h_r;
    n_nxt         = n_r;
    status_nxt    = status_r;
    owner_nxt     = owner_r;
    clr_nxt       = clr_r;
    count_nxt     = count_r;
    present_nxt   = present_r;
    key_we        = 1'b0;
    mod_start     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = h_r;
    ram_wdata     = '0;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IW'(RING_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt    = in_act;
          hnd_nxt    = in_hnd;
          key_nxt    = in_key;
          s_nxt      = s_eff;
          r_nxt      = r_eff;
          j_nxt      = '0;
          status_nxt = ST_OK;
          owner_nxt  = '0;
          state_nxt  = S_DONE;
          case (in_act)
            ACT_ADD: begin
              if (present_r[in_hnd]) begin
                status_nxt = ST_PRESENT;
              end else if (32'(need) >= 32'(s_eff)) begin
                status_nxt = ST_FULL;
              end else begin
                present_nxt[in_hnd] = 1'b1;
                key_we              = 1'b1;
                count_nxt           = count_r + 1'b1;
                state_nxt           = S_SQR;
              end
            end
            ACT_REMOVE: begin
              if (!present_r[in_hnd]) begin
                status_nxt = ST_UNKNOWN;
              end else begin
                key_nxt             = keys_r[in_hnd];
                present_nxt[in_hnd] = 1'b0;
                if (count_r != '0) begin
                  count_nxt = count_r - 1'b1;
                end
                state_nxt = S_SQR;
              end
            end
            ACT_LOOKUP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SQR;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SQR: begin
        ksq_nxt   = key_r * key_r;
        state_nxt = S_HASH;
      end
      S_HASH: begin
        mod_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (mod_stat.done) begin
          n_nxt = '0;
          if (act_r == ACT_LOOKUP) begin
            h_nxt = (rem_inc == s_r) ? '0 : rem_inc[IW-1:0];
          end else begin
            h_nxt = mod_rem[IW-1:0];
          end
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // probe one slot
        n_nxt = n_inc;
        h_nxt = (h_inc == s_r) ? '0 : h_inc[IW-1:0];
        state_nxt = S_RD;
        case (act_r)
          ACT_ADD: begin
            if (!rd_taken || n_inc == s_r) begin
              if (!rd_taken) begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, hnd_r};
              end
              j_nxt     = j_r + 1'b1;
              state_nxt = last_rep ? S_DONE : S_HASH;
            end
          end
          ACT_REMOVE: begin
            if ((rd_taken && rd_owner == hnd_r) || n_inc == s_r) begin
              if (rd_taken && rd_owner == hnd_r) begin
                ram_we = 1'b1;
              end
              j_nxt     = j_r + 1'b1;
              state_nxt = last_rep ? S_DONE : S_HASH;
            end
          end
          default: begin
            if (rd_taken) begin
              owner_nxt = rd_owner;
              state_nxt = S_DONE;
            end else if (n_inc == s_r) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, owner_r, status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    r_r        <= r_nxt;
    act_r      <= act_nxt;
    hnd_r      <= hnd_nxt;
    key_r      <= key_nxt;
    ksq_r      <= ksq_nxt;
    j_r        <= j_nxt;
    h_r        <= h_nxt;
    n_r        <= n_nxt;
    status_r   <= status_nxt;
    owner_r    <= owner_nxt;
    out_data_r <= out_data_nxt;
    if (key_we) begin
      keys_r[in_hnd] <= in_key;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/core/chr_checker.sv
// ----------------------------------------------------------------------------
// chr_checker
// Port-level checks of the hash ring, bound to the top level.
// ----------------------------------------------------------------------------
`include "consistent_hash_ring_assert.svh"

module chr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  import chr_pkg::*;

  // a stalled result holds
  `CHR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // status is always a defined code
  `CHR_ASSERT_NOW(a_status_range, out_tvalid, out_tdata[2:0] <= ST_PRESENT, "undefined status code")

  // owner is only reported with an ok status
  `CHR_ASSERT_NOW(a_owner_zero, out_tvalid && out_tdata[2:0] != ST_OK, out_tdata[6:3] == 4'd0, "owner set on failed request")

  // one request at a time
  `CHR_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready, "ready right after a request")

endmodule

bind consistent_hash_ring chr_checker u_chr_checker (.*);

### verif/tb_consistent_hash_ring.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_consistent_hash_ring
// Self-checking bench for the consistent hash ring: adds, removes and lookups
// are sent over the request stream while a behavioral ring model predicts
// each status and owner. Several ring sizes and replica counts are used,
// including out-of-range register values and changes with servers present.
// ----------------------------------------------------------------------------
module tb_consistent_hash_ring;
  import chr_pkg::*;

  localparam int          DEPTH          = 1024;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;
  localparam logic [2:0]  ADDR_RING_SIZE = 3'h0;
  localparam logic [2:0]  ADDR_REPLICAS  = 3'h4;
  localparam int          STALL_LIMIT    = 100000;

  typedef struct {
    logic [2:0] status;
    logic [3:0] owner;
  } ring_answer_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [23:0] in_tdata;    // [3:0] server_handle, [20:4] key, [23:21] zero
  logic [1:0]  in_tuser;    // [1:0] action
  logic        out_tvalid, out_tready;
  logic [7:0]  out_tdata;   // [2:0] status, [6:3] owner, [7] zero
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  // model of the ring
  bit [10:0]   m_ring_size;
  bit [3:0]    m_replicas;
  bit          m_taken [DEPTH];
  bit [3:0]    m_owner [DEPTH];
  bit          m_present [MAX_SERVERS];
  bit [16:0]   m_server_key [MAX_SERVERS];
  int unsigned m_count;

  ring_answer_t pending_answers[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit rx_quiet = 1'b0;
  bit tx_quiet = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  consistent_hash_ring u_dut (.*);

  always #5 clk = ~clk;

  // ring model
  function automatic ring_answer_t ring_predict(logic [1:0] act, logic [3:0] hnd,
                                                logic [16:0] key);
    ring_answer_t ans;
    longint unsigned s, r, h, k, n, j;
    bit found;
    ans.status = ST_OK;
    ans.owner  = 4'd0;
    s = (m_ring_size < 2) ? 2 : (m_ring_size > DEPTH) ? DEPTH : m_ring_size;
    r = (m_replicas < 1) ? 1 : (m_replicas > MAX_REPLICAS) ? MAX_REPLICAS : m_replicas;
    case (act)
      ACT_ADD: begin
        if (m_present[hnd]) begin
          ans.status = ST_PRESENT;
        end else if ((m_count + 1) * r >= s) begin
          ans.status = ST_FULL;
        end else begin
          m_count++;
          m_present[hnd] = 1'b1;
          m_server_key[hnd] = key;
          k = key;
          for (j = 0; j < r; j++) begin
            h = (k * k + j * j + 2 * j + 25) % s;
            for (n = 0; n < s && m_taken[h]; n++) h = (h + 1) % s;
            if (!m_taken[h]) begin
              m_taken[h] = 1'b1;
              m_owner[h] = hnd;
            end
          end
        end
      end
      ACT_REMOVE: begin
        if (!m_present[hnd]) begin
          ans.status = ST_UNKNOWN;
        end else begin
          k = m_server_key[hnd];
          for (j = 0; j < r; j++) begin
            h = (k * k + j * j + 2 * j + 25) % s;
            for (n = 0; n < s; n++) begin
              if (m_taken[h] && m_owner[h] == hnd) begin
                m_taken[h] = 1'b0;
                m_owner[h] = 4'd0;
                break;
              end
              h = (h + 1) % s;
            end
          end
          m_present[hnd] = 1'b0;
          if (m_count > 0) m_count--;
        end
      end
      ACT_LOOKUP: begin
        found = 1'b0;
        k = key;
        if (m_count != 0) begin
          h = ((k * k + 2 * k + 17) % s + 1) % s;
          for (n = 0; n < s; n++) begin
            if (m_taken[h]) begin
              found = 1'b1;
              ans.owner = m_owner[h];
              break;
            end
            h = (h + 1) % s;
          end
        end
        if (!found) ans.status = ST_EMPTY;
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  // send one request; tvalid stays high afterwards until a gap or a drain
  task automatic send_req(logic [1:0] act, logic [3:0] hnd, logic [16:0] key);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, key, hnd};
    do @(posedge clk); while (!in_tready);
    pending_answers.push_back(ring_predict(act, hnd, key));
    n_sent++;
  endtask

  // stop offering and wait for every expected answer
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write, only while the block is idle
  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_RING_SIZE) m_ring_size = data[10:0];
    else m_replicas = data[3:0];
  endtask

  task automatic set_ring(int size, int reps);
    drain();
    cfg_write(ADDR_RING_SIZE, size);
    cfg_write(ADDR_REPLICAS, reps);
  endtask

  // answer checker
  always @(posedge clk) begin
    ring_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected answer", 1, 0);
      end else begin
        want = pending_answers.pop_front();
        n_checked++;
        if (out_tdata[2:0] !== want.status)
          report_mismatch("status", out_tdata[2:0], want.status);
        if (out_tdata[6:3] !== want.owner)
          report_mismatch("owner", out_tdata[6:3], want.owner);
      end
    end
  end

  // answer receiver: random stalls, a few long, plus one requested long hold-off
  always @(posedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      out_tready <= 1'b0;
      rx_hold <= 400;
      long_hold_done <= 1'b1;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      rx_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // directed: empty ring, extreme keys and handles, duplicate, unknown, unused
  task automatic test_basic_ops();
    send_req(ACT_LOOKUP, 4'd0, 17'd5);
    send_req(ACT_ADD, 4'd0, 17'd0);
    send_req(ACT_ADD, 4'd15, 17'h1FFFF);
    send_req(ACT_ADD, 4'd0, 17'd77);
    send_req(ACT_LOOKUP, 4'd9, 17'd0);
    send_req(ACT_LOOKUP, 4'd6, 17'h1FFFF);
    send_req(ACT_REMOVE, 4'd5, 17'd0);
    send_req(ACT_UNUSED, 4'd15, 17'h1FFFF);
    send_req(ACT_REMOVE, 4'd15, 17'd0);
  endtask

  // ring full and register changes with servers present
  task automatic test_full_and_resize();
    set_ring(10, 3);
    send_req(ACT_ADD, 4'd1, 17'd3);
    send_req(ACT_ADD, 4'd2, 17'd12345);
    send_req(ACT_ADD, 4'd3, 17'h10000);
    send_req(ACT_LOOKUP, 4'd0, 17'd7);
    set_ring(0, 0);
    send_req(ACT_LOOKUP, 4'd0, 17'd1);
    send_req(ACT_ADD, 4'd4, 17'd9);
    send_req(ACT_REMOVE, 4'd1, 17'd0);
    set_ring(2047, 15);
    send_req(ACT_LOOKUP, 4'd0, 17'd99);
    send_req(ACT_REMOVE, 4'd2, 17'd0);
    send_req(ACT_REMOVE, 4'd3, 17'd0);
    send_req(ACT_REMOVE, 4'd0, 17'd0);
    send_req(ACT_LOOKUP, 4'd0, 17'd99);
  endtask

  // random mix of operations at one setting
  task automatic test_random(int size, int reps, int count);
    int pick;
    logic [1:0] act;
    logic [16:0] key;
    set_ring(size, reps);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      act = (pick < 35) ? ACT_ADD : (pick < 60) ? ACT_REMOVE : (pick < 96) ? ACT_LOOKUP
                                                                          : ACT_UNUSED;
      key = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 17'h1FFFF : 17'd0)
                                         : 17'($urandom());
      send_req(act, 4'($urandom_range(0, 15)), key);
      if (i % 150 == 149) drain();
    end
  endtask

  // receiver holds off long so the block backs up its input
  task automatic test_backpressure();
    drain();
    tx_quiet = 1'b1;
    long_hold_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_req((i % 2) ? ACT_LOOKUP : ACT_ADD, 4'(i), 17'($urandom()));
    drain();
    tx_quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    m_ring_size = 11'd1024;
    m_replicas = 4'd3;
    m_count = 0;
    foreach (m_taken[i]) begin
      m_taken[i] = 1'b0;
      m_owner[i] = 4'd0;
    end
    foreach (m_present[i]) m_present[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_full_and_resize();
    test_backpressure();
    test_random(64, 3, 400);
    rx_quiet = 1'b1;
    tx_quiet = 1'b1;
    test_random(17, 1, 300);
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
    test_random(1024, 8, 250);
    test_random(300, 5, 400);
    test_random(2, 1, 150);
    test_random(128, 2, 380);

    drain();
    repeat (50) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch("outstanding answers", pending_answers.size(), 0);
    $display("Sent %0d requests, checked %0d answers over ring sizes 2..1024 and 1..8 replicas",
             n_sent, n_checked);
    $display("including out-of-range registers, full ring, resize with servers, backpressure");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
